// ===== design/assert_macros.svh =====
// Shared assertion macros for the normalizer checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("normalizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("normalizer check failed");

`endif

// ===== design/vl2n_pkg.sv =====
package vl2n_pkg;

  // Default sizing of the element buffer and the element word.
  localparam int MAX_DIM_DEF    = 64;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int SUM_W      = 37;
  localparam int OUT_W      = 16;
  localparam int IDX_OUT_W  = 6;
  localparam int STATUS_W   = 2;

  // Quotient of a^2 * 2^32 / sum, saturated to 32 bits, and its square root.
  localparam int QUO_W  = 2 * OUT_W;
  localparam int ROOT_W = OUT_W;
  localparam int STEP_W = $clog2(QUO_W);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONFINITE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LONG      = 2'd3;

  // Configuration port layout: 64-bit registers at 8-byte slots.
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_SLOT_LSB = 3;
  localparam logic [CFG_ADDR_W-CFG_SLOT_LSB-1:0] REG_MIN_NORM_SQ = '0;
  localparam logic [SUM_W-1:0] MIN_NORM_RESET = 37'd1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;       // capture an accepted element beat
    logic accum;      // add the captured square into the sum
    logic clear;      // drop the vector state
    logic rd;         // read the buffer at the output index
    logic square;     // square the magnitude of the read element
    logic div_init;   // start the division and the root
    logic div_step;   // one restoring division step
    logic sqrt_step;  // one square root digit
    logic res_load;   // load the output register with an element result
    logic err_load;   // load the output register with the error result
    logic idx_inc;    // advance the output index
  } vl2n_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic last;       // the captured beat closed the vector
    logic has_err;    // the vector ends in an error result
    logic last_elem;  // the output index points at the final element
  } vl2n_stat_t;

endpackage

// ===== design/vl2n_if.sv =====
// Element input channel.
interface vl2n_in_if #(
  parameter int VALUE_BITS = vl2n_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] elem_value;
  logic                         not_finite;
  logic                         is_last;

  modport source(output valid, elem_value, not_finite, is_last, input ready);
  modport sink(input valid, elem_value, not_finite, is_last, output ready);
endinterface

// Result output channel.
interface vl2n_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vl2n_pkg::OUT_W-1:0]      norm_value;
  logic        [vl2n_pkg::IDX_OUT_W-1:0]  elem_index;
  logic        [vl2n_pkg::STATUS_W-1:0]   status;
  logic                                   last_out;

  modport source(output valid, norm_value, elem_index, status, last_out, input ready);
  modport sink(input valid, norm_value, elem_index, status, last_out, output ready);
endinterface

// ===== design/vl2n_datapath.sv =====
module vl2n_datapath #(
  parameter int MAX_DIM    = vl2n_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = vl2n_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vl2n_pkg::vl2n_cmd_t                  cmd,
  output vl2n_pkg::vl2n_stat_t                 stat,
  input  logic [VALUE_BITS-1:0]                in_value,
  input  logic                                 in_nf,
  input  logic                                 in_last,
  input  logic [vl2n_pkg::SUM_W-1:0]           min_norm_sq,
  output logic signed [vl2n_pkg::OUT_W-1:0]    norm_value,
  output logic [vl2n_pkg::IDX_OUT_W-1:0]       elem_index,
  output logic [vl2n_pkg::STATUS_W-1:0]        status,
  output logic                                 last_out
);

  localparam int SUM_W  = vl2n_pkg::SUM_W;
  localparam int OUT_W  = vl2n_pkg::OUT_W;
  localparam int QUO_W  = vl2n_pkg::QUO_W;
  localparam int ROOT_W = vl2n_pkg::ROOT_W;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SQ_W   = 2 * VALUE_BITS;
  localparam int ACC_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam int SREM_W = ROOT_W + 2;
  localparam int RND_W  = ROOT_W + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [OUT_W-1:0] POS_MAX = OUT_W'(2 ** (OUT_W - 1) - 1);

  // Vector state.
  logic [CNT_W-1:0]               cnt_r;
  logic [SUM_W-1:0]               sum_r;
  logic [vl2n_pkg::STATUS_W-1:0]  err_r;
  logic [IDX_W-1:0]               idx_r;
  logic                           last_r;
  logic [SQ_W-1:0]                sq_r;

  // Element buffer.
  logic [VALUE_BITS-1:0] buf_mem [MAX_DIM];
  logic [VALUE_BITS-1:0] rd_data_r;

  // Per-element arithmetic.
  logic                   neg_r;
  logic [SQ_W-1:0]        a2_r;
  logic                   sat_r;
  logic [SUM_W-1:0]       rem_r;
  logic [QUO_W-1:0]       q_r;
  logic [ROOT_W-1:0]      root_r;
  logic [SREM_W-1:0]      srem_r;

  // Output register.
  logic [OUT_W-1:0]                 norm_r;
  logic [vl2n_pkg::IDX_OUT_W-1:0]   idx_out_r;
  logic [vl2n_pkg::STATUS_W-1:0]    status_r;
  logic                             last_out_r;

  logic                           full;
  logic [VALUE_BITS-1:0]          in_mag;
  logic [SQ_W-1:0]                in_sq;
  logic [vl2n_pkg::STATUS_W-1:0]  err_nxt;
  logic [ACC_W-1:0]               acc;
  logic [SUM_W-1:0]               sum_nxt;
  logic [vl2n_pkg::STATUS_W-1:0]  final_code;
  logic [VALUE_BITS-1:0]          rd_mag;
  logic [SUM_W:0]                 rem2;
  logic                           div_ge;
  logic [SREM_W+1:0]              srem_sh;
  logic [SREM_W+1:0]              trial;
  logic                           sqrt_ge;
  logic [RND_W-1:0]               rnd;
  logic [OUT_W-1:0]               pos_val;
  logic [OUT_W-1:0]               neg_val;

  assign full = (cnt_r == CNT_W'(MAX_DIM));

  // Magnitude and square of the incoming element.
  assign in_mag = in_value[VALUE_BITS-1] ? (~in_value) + VALUE_BITS'(1) : in_value;
  assign in_sq  = SQ_W'(in_mag) * SQ_W'(in_mag);

  // A non-finite element overrides any error; an overflow beat sets too long once.
  always_comb begin
    err_nxt = err_r;
    if (in_nf) begin
      err_nxt = vl2n_pkg::ST_NONFINITE;
    end else if (full && err_r == vl2n_pkg::ST_OK) begin
      err_nxt = vl2n_pkg::ST_LONG;
    end
  end

  // Saturating sum of squares.
  assign acc     = ACC_W'(sum_r) + ACC_W'(sq_r);
  assign sum_nxt = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];

  // Status of the finished vector; a zero sum is too small unless an error is already set.
  always_comb begin
    final_code = err_r;
    if (err_r == vl2n_pkg::ST_OK && (sum_r == '0 || sum_r < min_norm_sq)) begin
      final_code = vl2n_pkg::ST_SMALL;
    end
  end

  assign stat.last      = last_r;
  assign stat.has_err   = (final_code != vl2n_pkg::ST_OK);
  assign stat.last_elem = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  // Vector control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      err_r  <= vl2n_pkg::ST_OK;
      idx_r  <= '0;
      last_r <= 1'b0;
    end else if (cmd.clear) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      err_r  <= vl2n_pkg::ST_OK;
      idx_r  <= '0;
      last_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (!full) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        err_r  <= err_nxt;
        last_r <= in_last;
      end
      if (cmd.accum) begin
        sum_r <= sum_nxt;
      end
      if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Square held for the accumulate cycle; dropped and non-finite beats add nothing.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_r <= (in_nf || full) ? '0 : in_sq;
    end
  end

  // Buffer write on capture, registered read during output.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      buf_mem[cnt_r[IDX_W-1:0]] <= in_value;
    end
    if (cmd.rd) begin
      rd_data_r <= buf_mem[idx_r];
    end
  end

  assign rd_mag = rd_data_r[VALUE_BITS-1] ? (~rd_data_r) + VALUE_BITS'(1) : rd_data_r;

  // Restoring division step on a^2 * 2^32 / sum.
  assign rem2   = {rem_r, 1'b0};
  assign div_ge = (rem2 >= {1'b0, sum_r});

  // Square root digit, two radicand bits per step.
  assign srem_sh = {srem_r, q_r[QUO_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign sqrt_ge = (srem_sh >= trial);

  // Element result: (root + 1) / 2, saturated for positive values.
  assign rnd     = (RND_W'(root_r) + RND_W'(1)) >> 1;
  assign pos_val = (rnd > RND_W'(POS_MAX)) ? POS_MAX : rnd[OUT_W-1:0];
  assign neg_val = OUT_W'(~rnd + RND_W'(1));

  // Per-element arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      neg_r <= rd_data_r[VALUE_BITS-1];
      a2_r  <= SQ_W'(rd_mag) * SQ_W'(rd_mag);
    end
    if (cmd.div_init) begin
      // A quotient of 2^32 or more means a^2 >= sum; the root then saturates.
      sat_r  <= (ACC_W'(a2_r) >= ACC_W'(sum_r));
      rem_r  <= SUM_W'(a2_r);
      root_r <= '0;
      srem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? SUM_W'(rem2 - {1'b0, sum_r}) : rem2[SUM_W-1:0];
      q_r   <= {q_r[QUO_W-2:0], sat_r | div_ge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sqrt_ge ? SREM_W'(srem_sh - trial) : SREM_W'(srem_sh);
      root_r <= {root_r[ROOT_W-2:0], sqrt_ge};
      q_r    <= q_r << 2;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      norm_r     <= neg_r ? neg_val : pos_val;
      idx_out_r  <= vl2n_pkg::IDX_OUT_W'(idx_r);
      status_r   <= vl2n_pkg::ST_OK;
      last_out_r <= stat.last_elem;
    end else if (cmd.err_load) begin
      norm_r     <= '0;
      idx_out_r  <= '0;
      status_r   <= final_code;
      last_out_r <= 1'b1;
    end
  end

  assign norm_value = norm_r;
  assign elem_index = idx_out_r;
  assign status     = status_r;
  assign last_out   = last_out_r;

endmodule

// ===== design/vl2n_ctrl.sv =====
module vl2n_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  vl2n_pkg::vl2n_stat_t  stat,
  output vl2n_pkg::vl2n_cmd_t   cmd
);

  localparam int STEP_W = vl2n_pkg::STEP_W;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_JUDGE = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_DINIT = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ROOT  = 4'd7;
  localparam logic [3:0] S_FMT   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]        state_r;
  logic [3:0]        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);

  // Sequencer: capture and accumulate each beat, then give the error result or divide and root each element.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = stat.last ? S_JUDGE : S_LOAD;
      end
      S_JUDGE: begin
        if (stat.has_err) begin
          cmd.err_load = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(vl2n_pkg::QUO_W - 1)) begin
          step_nxt  = '0;
          state_nxt = S_ROOT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == STEP_W'(vl2n_pkg::ROOT_W - 1)) begin
          step_nxt  = '0;
          state_nxt = S_FMT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_FMT: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.has_err || stat.last_elem) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== design/vector_l2_normalize_top.sv =====
// Channel  Direction  Handshake       Beat contents
// in_ch    in         valid / ready   elem_value, not_finite, is_last
// out_ch   out        valid / ready   norm_value, elem_index, status, last_out
// APB      in         psel / penable  min_norm_sq, 64-bit register at byte 0
//
// Each input beat is captured and squared, then accumulated into the sum; no new beat is
// taken before that. An error result follows the last accumulate. Each normalized
// element starts from its buffer read: a 32-step restoring division of a^2 * 2^32
// by the sum, then a 16-step square root, one step per cycle in the shared datapath.
// in_ch.ready stays low from the last beat until the final result beat is taken; a
// stalled out_ch holds the sequencer. Synchronous reset clears the vector state and
// sets min_norm_sq to 1; the element buffer is not cleared.
module vector_l2_normalize_top #(
  parameter int MAX_DIM    = vl2n_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = vl2n_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  vl2n_in_if.sink                             in_ch,
  vl2n_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vl2n_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [vl2n_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [vl2n_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int SUM_W = vl2n_pkg::SUM_W;

  vl2n_pkg::vl2n_cmd_t   cmd;
  vl2n_pkg::vl2n_stat_t  stat;
  logic [SUM_W-1:0]      min_norm_r;
  logic [vl2n_pkg::CFG_ADDR_W-vl2n_pkg::CFG_SLOT_LSB-1:0] slot;
  logic                  cfg_wr;

  // Register slot decode.
  assign slot   = paddr[vl2n_pkg::CFG_ADDR_W-1:vl2n_pkg::CFG_SLOT_LSB];
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_r <= vl2n_pkg::MIN_NORM_RESET;
    end else if (cfg_wr && slot == vl2n_pkg::REG_MIN_NORM_SQ) begin
      min_norm_r <= pwdata[SUM_W-1:0];
    end
  end

  assign prdata = (slot == vl2n_pkg::REG_MIN_NORM_SQ) ?
                  vl2n_pkg::CFG_DATA_W'(min_norm_r) : '0;

  vl2n_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vl2n_datapath #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_value    (in_ch.elem_value),
    .in_nf       (in_ch.not_finite),
    .in_last     (in_ch.is_last),
    .min_norm_sq (min_norm_r),
    .norm_value  (out_ch.norm_value),
    .elem_index  (out_ch.elem_index),
    .status      (out_ch.status),
    .last_out    (out_ch.last_out)
  );

endmodule

// ===== design/vl2n_checker.sv =====
`include "assert_macros.svh"

module vl2n_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [vl2n_pkg::OUT_W-1:0]           norm_value,
  input logic [vl2n_pkg::IDX_OUT_W-1:0]       elem_index,
  input logic [vl2n_pkg::STATUS_W-1:0]        status,
  input logic                                 last_out
);

  logic [vl2n_pkg::OUT_W+vl2n_pkg::IDX_OUT_W+vl2n_pkg::STATUS_W:0] out_beat;
  logic                                                           err_shape_ok;

  // The whole result beat, and the fixed shape of an error beat.
  assign out_beat     = {norm_value, elem_index, status, last_out};
  assign err_shape_ok = (norm_value == '0) && (elem_index == '0) && last_out;

  // A stalled result beat stays valid and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_beat))

  // No element is taken while a result is on offer.
  `ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)

  // An accepted beat is always followed by its accumulate cycle.
  `ASSERT_NEXT(a_accum_gap, clk, rst_n, in_valid && in_ready, !out_valid && !in_ready)

  // An error result is a single closing beat with zero value and index.
  `ASSERT_IMPLY(a_err_shape, clk, rst_n, out_valid && status != vl2n_pkg::ST_OK, err_shape_ok)

endmodule

bind vector_l2_normalize_top vl2n_checker u_vl2n_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .norm_value (out_ch.norm_value),
  .elem_index (out_ch.elem_index),
  .status     (out_ch.status),
  .last_out   (out_ch.last_out)
);
